// ===== sv/lr3q_pkg.sv =====
// ----------------------------------------------------------------------------
// lr3q_pkg
// Shared types, constants and tables of the layer 3 line requantizer.
// ----------------------------------------------------------------------------
package lr3q_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SH_BASE     = 45 - FRAC_BITS;
    localparam int QV_W        = 15;
    localparam int X_W         = 14;
    localparam int QV_LIMIT    = 8206;
    localparam int GAIN_BIAS   = 210;
    localparam int E_W         = 10;
    localparam int CBRT_STAGES = 22;
    localparam int CBRT_TOP    = 3 * (CBRT_STAGES - 1);
    localparam int CBRT_SHIFT  = 48;
    localparam int REM_W       = X_W + CBRT_SHIFT;
    localparam int Y_W         = 22;
    localparam int SQ_W        = 2 * Y_W;
    localparam int B_W         = SQ_W + 2;
    localparam int M_W         = 34;
    localparam int M_HALF      = M_W / 2;
    localparam int K_W         = 30;
    localparam int PP_W        = M_HALF + K_W;
    localparam int P_W         = 64;
    localparam int SH_W        = 7;
    localparam int OUT_W       = 48;
    localparam int FIFO_DEPTH  = 32;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    typedef logic [REM_W-1:0]      t_rem;
    typedef logic [Y_W-1:0]        t_y;
    typedef logic [SQ_W-1:0]       t_sq;
    typedef logic [B_W-1:0]        t_b;
    typedef logic [M_W-1:0]        t_m;
    typedef logic [K_W-1:0]        t_k;
    typedef logic [PP_W-1:0]       t_pp;
    typedef logic [P_W-1:0]        t_p;
    typedef logic [OUT_W-1:0]      t_sample;
    typedef logic [FIFO_AW:0]      t_count;

    localparam t_sample OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_CODE     = 3'd0,
        CFG_COARSE_SCALE  = 3'd1,
        CFG_PRE_EMPHASIS  = 3'd2,
        CFG_SHORT_BLOCKS  = 3'd3,
        CFG_WINDOW_GAIN_A = 3'd4,
        CFG_WINDOW_GAIN_B = 3'd5,
        CFG_WINDOW_GAIN_C = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] gain_code;
        logic       coarse_scale;
        logic       pre_emphasis;
        logic       short_blocks;
        logic [2:0] window_gain_a;
        logic [2:0] window_gain_b;
        logic [2:0] window_gain_c;
    } t_cfg;

    typedef struct packed {
        logic [3:0]      scalefactor;
        logic [1:0]      window;
        logic [4:0]      band;
        logic [QV_W-1:0] quant_value;
    } t_item;

    typedef struct packed {
        logic                  neg;
        logic [X_W-1:0]        x;
        logic signed [E_W-1:0] e;
    } t_side;

    function automatic logic [1:0] pretab(input logic [4:0] i_band);
        logic [1:0] v;
        case (i_band) inside
            [5'd11:5'd14]:        v = 2'd1;
            [5'd15:5'd16], 5'd20: v = 2'd2;
            [5'd17:5'd19]:        v = 2'd3;
            default:              v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic t_k quarter_pow(input logic [1:0] i_f);
        t_k v;
        case (i_f)
            2'd0: v = 30'd536870912;
            2'd1: v = 30'd638450708;
            2'd2: v = 30'd759250125;
            2'd3: v = 30'd902905651;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/layer3_line_requantizer.sv =====
// ----------------------------------------------------------------------------
// layer3_line_requantizer
// Requantizes one layer 3 spectral line per request into signed fixed point.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one quantized line per request; m_axis returns one
//   48-bit sample per request, in order. granule settings come in through
//   the cfg write port; the user must change them only while no request is
//   in flight, and the block itself does not enforce this. throughput is
//   one line per cycle while s_axis_tready is high, set by the 22-stage cube
//   root pipeline and the two-stage split gain multiply behind it.
//   the pipeline never stalls: a 32-entry result buffer sits at the output
//   and s_axis_tready stays high while fewer than 32 requests are in flight.
//   when the receiver holds m_axis_tready low, results collect in the buffer
//   and input is taken until that window is full.
//   reset is synchronous: it empties the pipeline and the buffer and loads
//   gain_code 210 and zero into the other settings.
// ----------------------------------------------------------------------------
module layer3_line_requantizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [lr3q_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lr3q_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // quant_value[14:0], band[19:15], window[21:20], scalefactor[25:22], zero pad
    input  logic [31:0]                          s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // sample[47:0]
    output logic [47:0]                          m_axis_tdata
);

    lr3q_pkg::t_cfg    r_cfg;
    lr3q_pkg::t_item   r_in;
    logic              r_in_vld;
    lr3q_pkg::t_count  r_credit;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_front_vld;
    lr3q_pkg::t_side   w_front_side;
    logic              w_root_vld;
    lr3q_pkg::t_side   w_root_side;
    lr3q_pkg::t_y      w_root;
    logic              w_res_vld;
    lr3q_pkg::t_sample w_res;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_credit < lr3q_pkg::t_count'(lr3q_pkg::FIFO_DEPTH));

    // settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_code     <= 8'(lr3q_pkg::GAIN_BIAS);
            r_cfg.coarse_scale  <= 1'b0;
            r_cfg.pre_emphasis  <= 1'b0;
            r_cfg.short_blocks  <= 1'b0;
            r_cfg.window_gain_a <= 3'd0;
            r_cfg.window_gain_b <= 3'd0;
            r_cfg.window_gain_c <= 3'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lr3q_pkg::CFG_GAIN_CODE:     r_cfg.gain_code     <= i_cfg_data;
                lr3q_pkg::CFG_COARSE_SCALE:  r_cfg.coarse_scale  <= i_cfg_data[0];
                lr3q_pkg::CFG_PRE_EMPHASIS:  r_cfg.pre_emphasis  <= i_cfg_data[0];
                lr3q_pkg::CFG_SHORT_BLOCKS:  r_cfg.short_blocks  <= i_cfg_data[0];
                lr3q_pkg::CFG_WINDOW_GAIN_A: r_cfg.window_gain_a <= i_cfg_data[2:0];
                lr3q_pkg::CFG_WINDOW_GAIN_B: r_cfg.window_gain_b <= i_cfg_data[2:0];
                lr3q_pkg::CFG_WINDOW_GAIN_C: r_cfg.window_gain_c <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        r_in <= lr3q_pkg::t_item'(s_axis_tdata[$bits(lr3q_pkg::t_item)-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_credit <= '0;
        end else begin
            r_in_vld <= w_in_acc;
            r_credit <= r_credit + lr3q_pkg::t_count'(w_in_acc)
                      - lr3q_pkg::t_count'(w_out_acc);
        end
    end

    lr3q_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_vld   (w_front_vld),
        .o_side  (w_front_side)
    );

    lr3q_cbrt u_cbrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_side  (w_front_side),
        .o_vld   (w_root_vld),
        .o_side  (w_root_side),
        .o_root  (w_root)
    );

    lr3q_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_root_vld),
        .i_side   (w_root_side),
        .i_root   (w_root),
        .o_vld    (w_res_vld),
        .o_sample (w_res)
    );

    lr3q_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_res_vld),
        .i_wr_data (w_res),
        .i_rd_en   (w_out_acc),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= lr3q_pkg::t_count'(lr3q_pkg::FIFO_DEPTH))
        else $error("credit count above buffer depth");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> (r_credit != '0))
        else $error("pipeline result without an outstanding request");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_credit != '0))
        else $error("output valid without an outstanding request");

    a_credit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_out_acc) |=> (r_credit == $past(r_credit) + 1'b1))
        else $error("credit count missed an accepted request");
`endif

endmodule

// ===== sv/lr3q_front.sv =====
// ----------------------------------------------------------------------------
// lr3q_front
// Magnitude, clamp and quarter-step exponent of one line.
// ----------------------------------------------------------------------------
module lr3q_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  lr3q_pkg::t_item  i_item,
    input  lr3q_pkg::t_cfg   i_cfg,
    output logic             o_vld,
    output lr3q_pkg::t_side  o_side
);

    logic                      w_neg;
    logic [lr3q_pkg::QV_W-1:0] w_mag;
    logic [2:0]                w_wg;
    logic [1:0]                w_pre;
    logic [4:0]                w_sf_sum;
    logic [6:0]                w_sf_term;
    logic [10:0]               w_e;
    lr3q_pkg::t_side           n_side;
    lr3q_pkg::t_side           r_side;
    logic                      r_vld;

    always_comb begin
        w_neg = i_item.quant_value[lr3q_pkg::QV_W-1];
        w_mag = w_neg ? (~i_item.quant_value + 1'b1) : i_item.quant_value;

        w_wg  = 3'd0;
        w_pre = 2'd0;
        if (i_cfg.short_blocks) begin
            case (i_item.window)
                2'd0:    w_wg = i_cfg.window_gain_a;
                2'd1:    w_wg = i_cfg.window_gain_b;
                2'd2:    w_wg = i_cfg.window_gain_c;
                default: w_wg = 3'd0;
            endcase
        end else if (i_cfg.pre_emphasis) begin
            w_pre = lr3q_pkg::pretab(i_item.band);
        end

        w_sf_sum  = 5'(i_item.scalefactor) + 5'(w_pre);
        w_sf_term = i_cfg.coarse_scale ? {w_sf_sum, 2'b00} : {1'b0, w_sf_sum, 1'b0};
        w_e = 11'(i_cfg.gain_code) - 11'(lr3q_pkg::GAIN_BIAS)
            - 11'({w_wg, 3'b000}) - 11'(w_sf_term);

        n_side.neg = w_neg;
        n_side.x   = (w_mag > lr3q_pkg::QV_W'(lr3q_pkg::QV_LIMIT))
                   ? lr3q_pkg::X_W'(lr3q_pkg::QV_LIMIT) : w_mag[lr3q_pkg::X_W-1:0];
        n_side.e   = signed'(w_e[lr3q_pkg::E_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;

endmodule

// ===== sv/lr3q_cbrt.sv =====
// ----------------------------------------------------------------------------
// lr3q_cbrt
// Pipelined integer cube root of x * 2^48, one result bit per stage.
// ----------------------------------------------------------------------------
module lr3q_cbrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  lr3q_pkg::t_side  i_side,
    output logic             o_vld,
    output lr3q_pkg::t_side  o_side,
    output lr3q_pkg::t_y     o_root
);

    localparam int NS = lr3q_pkg::CBRT_STAGES;

    lr3q_pkg::t_y    r_y    [NS];
    lr3q_pkg::t_sq   r_sq   [NS];
    lr3q_pkg::t_rem  r_rem  [NS];
    lr3q_pkg::t_side r_side [NS];
    logic [NS-1:0]   r_vld;

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam int S = lr3q_pkg::CBRT_TOP - 3 * i;

        lr3q_pkg::t_y    w_y_in;
        lr3q_pkg::t_sq   w_sq_in;
        lr3q_pkg::t_rem  w_rem_in;
        lr3q_pkg::t_side w_side_in;
        logic            w_vld_in;
        lr3q_pkg::t_y    w_y2;
        lr3q_pkg::t_sq   w_sq2;
        lr3q_pkg::t_b    w_t;
        lr3q_pkg::t_b    w_b;
        logic            w_take;
        lr3q_pkg::t_rem  w_sub;
        lr3q_pkg::t_y    n_y;
        lr3q_pkg::t_sq   n_sq;
        lr3q_pkg::t_rem  n_rem;

        if (i == 0) begin : g_first
            assign w_y_in    = '0;
            assign w_sq_in   = '0;
            assign w_rem_in  = lr3q_pkg::t_rem'(i_side.x) << lr3q_pkg::CBRT_SHIFT;
            assign w_side_in = i_side;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_y_in    = r_y[i-1];
            assign w_sq_in   = r_sq[i-1];
            assign w_rem_in  = r_rem[i-1];
            assign w_side_in = r_side[i-1];
            assign w_vld_in  = r_vld[i-1];
        end

        always_comb begin
            w_y2   = w_y_in << 1;
            w_sq2  = w_sq_in << 2;
            w_t    = lr3q_pkg::t_b'(w_sq2) + lr3q_pkg::t_b'(w_y2);
            w_b    = (w_t << 1) + w_t + 1'b1;
            w_take = (w_rem_in >> S) >= lr3q_pkg::t_rem'(w_b);
            w_sub  = lr3q_pkg::t_rem'(64'(w_b) << S);
            n_y    = w_take ? (w_y2 | lr3q_pkg::t_y'(1)) : w_y2;
            n_sq   = w_take ? (w_sq2 + (lr3q_pkg::t_sq'(w_y2) << 1) + 1'b1) : w_sq2;
            n_rem  = w_take ? (w_rem_in - w_sub) : w_rem_in;
        end

        always_ff @(posedge i_clk) begin
            r_y[i]    <= n_y;
            r_sq[i]   <= n_sq;
            r_rem[i]  <= n_rem;
            r_side[i] <= w_side_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= w_vld_in;
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_side = r_side[NS-1];
    assign o_root = r_y[NS-1];

endmodule

// ===== sv/lr3q_scale.sv =====
// ----------------------------------------------------------------------------
// lr3q_scale
// Power product, quarter-step gain, shift, rounding, saturation and sign.
// ----------------------------------------------------------------------------
module lr3q_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  lr3q_pkg::t_side   i_side,
    input  lr3q_pkg::t_y      i_root,
    output logic              o_vld,
    output lr3q_pkg::t_sample o_sample
);

    logic [3:0]                     r_vld;
    logic [3:0]                     r_neg;
    logic signed [lr3q_pkg::E_W-1:0] r_e_m;
    logic signed [lr3q_pkg::E_W-1:0] r_e_pp;
    lr3q_pkg::t_m                   r_m;
    lr3q_pkg::t_pp                  r_pp_lo;
    lr3q_pkg::t_pp                  r_pp_hi;
    lr3q_pkg::t_p                   r_p;
    logic [lr3q_pkg::SH_W-1:0]      r_sh;
    logic [lr3q_pkg::P_W:0]         r_v;

    logic [35:0]                     w_mx;
    lr3q_pkg::t_k                    w_k;
    logic signed [lr3q_pkg::E_W-1:0] w_a;
    logic [lr3q_pkg::E_W-1:0]        w_sh;
    lr3q_pkg::t_m                    n_m;
    lr3q_pkg::t_pp                   n_pp_lo;
    lr3q_pkg::t_pp                   n_pp_hi;
    lr3q_pkg::t_p                    n_p;
    logic [lr3q_pkg::P_W:0]          n_v;
    logic [lr3q_pkg::P_W-1:0]        w_q;
    logic [lr3q_pkg::P_W:0]          w_sum;
    lr3q_pkg::t_sample               w_mag;

    always_comb begin
        w_mx    = 36'(i_side.x) * 36'(i_root);
        n_m     = w_mx[lr3q_pkg::M_W-1:0];

        w_k     = lr3q_pkg::quarter_pow(r_e_m[1:0]);
        n_pp_lo = lr3q_pkg::t_pp'(r_m[lr3q_pkg::M_HALF-1:0]) * lr3q_pkg::t_pp'(w_k);
        n_pp_hi = lr3q_pkg::t_pp'(r_m[lr3q_pkg::M_W-1:lr3q_pkg::M_HALF])
                * lr3q_pkg::t_pp'(w_k);

        n_p     = lr3q_pkg::t_p'(r_pp_lo)
                + (lr3q_pkg::t_p'(r_pp_hi) << lr3q_pkg::M_HALF);
        w_a     = r_e_pp >>> 2;
        w_sh    = lr3q_pkg::E_W'(lr3q_pkg::SH_BASE) - w_a;

        n_v     = {r_p, 1'b0} >> r_sh;

        // rounding bit sits below the kept part; a zero kept part flushes
        w_q     = r_v[lr3q_pkg::P_W:1];
        w_sum   = (lr3q_pkg::P_W+1)'(w_q) + (lr3q_pkg::P_W+1)'(r_v[0]);
        if (w_q == '0) begin
            w_mag = '0;
        end else if (|w_sum[lr3q_pkg::P_W:lr3q_pkg::OUT_W-1]) begin
            w_mag = lr3q_pkg::OUT_MAX;
        end else begin
            w_mag = w_sum[lr3q_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_e_m   <= i_side.e;
        r_pp_lo <= n_pp_lo;
        r_pp_hi <= n_pp_hi;
        r_e_pp  <= r_e_m;
        r_p     <= n_p;
        r_sh    <= w_sh[lr3q_pkg::SH_W-1:0];
        r_v     <= n_v;
        r_neg   <= {r_neg[2:0], i_side.neg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    assign o_vld    = r_vld[3];
    assign o_sample = r_neg[3] ? (~w_mag + 1'b1) : w_mag;

endmodule

// ===== sv/lr3q_fifo.sv =====
// ----------------------------------------------------------------------------
// lr3q_fifo
// Result buffer between the fixed-latency pipeline and the output stream.
// ----------------------------------------------------------------------------
module lr3q_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  lr3q_pkg::t_sample i_wr_data,
    input  logic              i_rd_en,
    output logic              o_valid,
    output lr3q_pkg::t_sample o_data
);

    lr3q_pkg::t_sample            r_mem [lr3q_pkg::FIFO_DEPTH];
    logic [lr3q_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [lr3q_pkg::FIFO_AW-1:0] r_rd_ptr;
    lr3q_pkg::t_count             r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + lr3q_pkg::t_count'(i_wr_en)
                     - lr3q_pkg::t_count'(i_rd_en);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule
